/* rtl/core/text_terminal_grid_engine_unit_assert.svh */
// ----------------------------------------------------------------------------
// Text terminal grid engine assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_GRID_ENGINE_UNIT_ASSERT_SVH
`define TEXT_TERMINAL_GRID_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TTGE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TTGE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ttge_pkg.sv */
// ----------------------------------------------------------------------------
// ttge_pkg
// Types, byte codes and defaults shared by the terminal grid engine modules.
// ----------------------------------------------------------------------------
package ttge_pkg;

   // default grid size
   localparam int unsigned DEF_COLUMNS = 80;
   localparam int unsigned DEF_ROWS    = 24;

   // terminal byte codes
   localparam logic [7:0] CHAR_BS       = 8'h08;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_ESC      = 8'h1B;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_DEL      = 8'h7F;
   localparam logic [7:0] PRINT_LO      = 8'h20;
   localparam logic [7:0] PRINT_HI      = 8'h7E;
   localparam logic [7:0] CSI_FINAL_LO  = 8'h40;
   localparam logic [7:0] CSI_FINAL_HI  = 8'h7E;
   localparam logic [6:0] CELL_BLANK    = 7'h20;

   // escape parser phase
   typedef enum logic [1:0] {
      PHASE_NORMAL = 2'd0,
      PHASE_ESC    = 2'd1,
      PHASE_CSI    = 2'd2
   } phase_type;

   // class of a byte seen in the normal phase
   typedef enum logic [2:0] {
      BCLS_OTHER,
      BCLS_ESC,
      BCLS_LF,
      BCLS_CR,
      BCLS_ERASE,
      BCLS_TAB,
      BCLS_PRINT
   } bcls_type;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LATCH,
      CMD_CLEAR_STEP,
      CMD_ESCAPE,
      CMD_NEWLINE,
      CMD_RETURN,
      CMD_ERASE,
      CMD_TAB_START,
      CMD_TAB_STEP,
      CMD_SCROLL_STEP,
      CMD_PUT,
      CMD_RESPOND
   } cmd_type;

   // datapath status toward the controller
   typedef struct packed {
      logic      is_read;
      phase_type phase;
      bcls_type  bcls;
      logic      col_zero;
      logic      col_pending;
      logic      line_last;
      logic      tab_done;
      logic      scroll_last;
      logic      clear_last;
   } status_type;

endpackage

/* rtl/core/ttge_dp.sv */
// ----------------------------------------------------------------------------
// ttge_dp
// Grid memory, cursor, escape phase and scroll offset. The grid is a ring of
// rows: a scroll advances the top row and blanks the row that leaves it.
// ----------------------------------------------------------------------------
module ttge_dp #(
   parameter int unsigned COLUMNS = ttge_pkg::DEF_COLUMNS,
   parameter int unsigned ROWS    = ttge_pkg::DEF_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ttge_pkg::cmd_type    cmd,
   input  logic                 req_type,
   input  logic [7:0]           req_data_byte,
   input  logic [4:0]           req_read_row,
   input  logic [6:0]           req_read_col,
   output ttge_pkg::status_type status,
   output logic [6:0]           rsp_cell_char,
   output logic [6:0]           rsp_cursor_col,
   output logic [4:0]           rsp_cursor_row,
   output logic [1:0]           rsp_escape_phase
);

   localparam int unsigned DEPTH  = ROWS * COLUMNS;
   localparam int unsigned COL_W  = $clog2(COLUMNS + 1);
   localparam int unsigned ROW_W  = $clog2(ROWS);
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam logic [ROW_W:0]    ROWS_EXT  = (ROW_W + 1)'(ROWS);
   localparam logic [COL_W:0]    COLS_EXT  = (COL_W + 1)'(COLUMNS);
   localparam logic [COL_W-1:0]  COLS_END  = COL_W'(COLUMNS);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] SCR_LAST  = ADDR_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] COLS_ADDR = ADDR_W'(COLUMNS);

   // grid storage
   logic [6:0] grid_mem [DEPTH];

   // latched request
   logic             req_type_ff;
   logic [7:0]       byte_ff;
   logic [4:0]       rrow_ff;
   logic [6:0]       rcol_ff;

   // control state
   logic [COL_W-1:0]  col_ff,   col_in;
   logic [ROW_W-1:0]  line_ff,  line_in;
   ttge_pkg::phase_type phase_ff, phase_in;
   logic [ROW_W-1:0]  top_ff,   top_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [COL_W-1:0]  stop_ff,  stop_in;

   logic [6:0]        rd_data_ff;

   logic [ROW_W:0]    line_sum;
   logic [ROW_W-1:0]  line_prow;
   logic [ROW_W:0]    read_sum;
   logic [ROW_W-1:0]  read_prow;
   logic [ROW_W:0]    top_sum;
   logic [COL_W:0]    tab_sum;
   logic [COL_W:0]    tab_stop;
   logic              rd_in_range;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic              wr_linear;
   logic [ROW_W-1:0]  wr_row;
   logic [COL_W-1:0]  wr_col;
   logic [6:0]        wr_data;
   logic [ADDR_W-1:0] wr_addr;
   ttge_pkg::bcls_type bcls;

   // logical row to physical row
   always_comb begin
      line_sum  = {1'b0, line_ff} + {1'b0, top_ff};
      line_prow = (line_sum >= ROWS_EXT) ? ROW_W'(line_sum - ROWS_EXT) : ROW_W'(line_sum);
      read_sum  = {1'b0, ROW_W'(rrow_ff)} + {1'b0, top_ff};
      read_prow = (read_sum >= ROWS_EXT) ? ROW_W'(read_sum - ROWS_EXT) : ROW_W'(read_sum);
      top_sum   = {1'b0, top_ff} + (ROW_W + 1)'(1);
   end

   // read port address, out-of-range reads park at zero
   always_comb begin
      rd_in_range = (32'(rrow_ff) < ROWS) && (32'(rcol_ff) < COLUMNS);
      rd_addr     = rd_in_range ? (ADDR_W'(read_prow) * COLS_ADDR + ADDR_W'(rcol_ff)) : '0;
   end

   // next tab stop, clamped to the pending-wrap column
   always_comb begin
      tab_sum  = (COL_W + 1)'(col_ff) + (COL_W + 1)'(8);
      tab_stop = tab_sum & ~(COL_W + 1)'(7);
      if (tab_stop > COLS_EXT) begin
         tab_stop = COLS_EXT;
      end
   end

   // byte decode
   always_comb begin
      unique case (byte_ff) inside
         ttge_pkg::CHAR_ESC:                        bcls = ttge_pkg::BCLS_ESC;
         ttge_pkg::CHAR_LF:                         bcls = ttge_pkg::BCLS_LF;
         ttge_pkg::CHAR_CR:                         bcls = ttge_pkg::BCLS_CR;
         ttge_pkg::CHAR_BS, ttge_pkg::CHAR_DEL:     bcls = ttge_pkg::BCLS_ERASE;
         ttge_pkg::CHAR_TAB:                        bcls = ttge_pkg::BCLS_TAB;
         [ttge_pkg::PRINT_LO:ttge_pkg::PRINT_HI]:   bcls = ttge_pkg::BCLS_PRINT;
         default:                                   bcls = ttge_pkg::BCLS_OTHER;
      endcase
   end

   // write port select
   always_comb begin
      wr_en     = 1'b0;
      wr_linear = 1'b0;
      wr_row    = line_prow;
      wr_col    = col_ff;
      wr_data   = ttge_pkg::CELL_BLANK;
      case (cmd)
         ttge_pkg::CMD_CLEAR_STEP: begin
            wr_en     = 1'b1;
            wr_linear = 1'b1;
         end
         ttge_pkg::CMD_SCROLL_STEP: begin
            wr_en  = 1'b1;
            wr_row = top_ff;
            wr_col = COL_W'(sweep_ff);
         end
         ttge_pkg::CMD_ERASE: begin
            wr_en  = 1'b1;
            wr_col = col_ff - COL_W'(1);
         end
         ttge_pkg::CMD_TAB_STEP: begin
            wr_en = 1'b1;
         end
         ttge_pkg::CMD_PUT: begin
            wr_en   = 1'b1;
            wr_data = byte_ff[6:0];
         end
         default: ;
      endcase
      wr_addr = wr_linear ? sweep_ff : (ADDR_W'(wr_row) * COLS_ADDR + ADDR_W'(wr_col));
   end

   // status toward the controller
   always_comb begin
      status.is_read     = req_type_ff;
      status.phase       = phase_ff;
      status.bcls        = bcls;
      status.col_zero    = (col_ff == '0);
      status.col_pending = (col_ff == COLS_END);
      status.line_last   = (line_ff == ROW_LAST);
      status.tab_done    = (col_ff >= stop_ff);
      status.scroll_last = (sweep_ff == SCR_LAST);
      status.clear_last  = (sweep_ff == CLR_LAST);
   end

   // next state of cursor, phase, ring offset and sweep counter
   always_comb begin
      col_in   = col_ff;
      line_in  = line_ff;
      phase_in = phase_ff;
      top_in   = top_ff;
      sweep_in = sweep_ff;
      stop_in  = stop_ff;
      case (cmd)
         ttge_pkg::CMD_CLEAR_STEP: begin
            sweep_in = status.clear_last ? '0 : sweep_ff + ADDR_W'(1);
         end
         ttge_pkg::CMD_ESCAPE: begin
            case (phase_ff)
               ttge_pkg::PHASE_ESC: begin
                  phase_in = (byte_ff == ttge_pkg::CHAR_LBRACKET) ?
                             ttge_pkg::PHASE_CSI : ttge_pkg::PHASE_NORMAL;
               end
               ttge_pkg::PHASE_CSI: begin
                  if (byte_ff >= ttge_pkg::CSI_FINAL_LO && byte_ff <= ttge_pkg::CSI_FINAL_HI) begin
                     phase_in = ttge_pkg::PHASE_NORMAL;
                  end
               end
               default: phase_in = ttge_pkg::PHASE_ESC;
            endcase
         end
         ttge_pkg::CMD_NEWLINE: begin
            col_in = '0;
            if (!status.line_last) begin
               line_in = line_ff + ROW_W'(1);
            end
         end
         ttge_pkg::CMD_RETURN:    col_in = '0;
         ttge_pkg::CMD_ERASE:     col_in = col_ff - COL_W'(1);
         ttge_pkg::CMD_TAB_START: stop_in = COL_W'(tab_stop);
         ttge_pkg::CMD_TAB_STEP:  col_in = col_ff + COL_W'(1);
         ttge_pkg::CMD_SCROLL_STEP: begin
            if (status.scroll_last) begin
               sweep_in = '0;
               top_in   = (top_sum == ROWS_EXT) ? '0 : ROW_W'(top_sum);
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         ttge_pkg::CMD_PUT:       col_in = col_ff + COL_W'(1);
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         line_ff  <= '0;
         phase_ff <= ttge_pkg::PHASE_NORMAL;
         top_ff   <= '0;
         sweep_ff <= '0;
         stop_ff  <= '0;
      end else begin
         col_ff   <= col_in;
         line_ff  <= line_in;
         phase_ff <= phase_in;
         top_ff   <= top_in;
         sweep_ff <= sweep_in;
         stop_ff  <= stop_in;
      end
   end

   // grid memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= grid_mem[rd_addr];
   end

   // request latch and result word
   always_ff @(posedge clock) begin
      if (cmd == ttge_pkg::CMD_LATCH) begin
         req_type_ff <= req_type;
         byte_ff     <= req_data_byte;
         rrow_ff     <= req_read_row;
         rcol_ff     <= req_read_col;
      end
      if (cmd == ttge_pkg::CMD_RESPOND) begin
         rsp_cell_char    <= (req_type_ff && rd_in_range) ? rd_data_ff : 7'd0;
         rsp_cursor_col   <= 7'(col_ff);
         rsp_cursor_row   <= 5'(line_ff);
         rsp_escape_phase <= phase_ff;
      end
   end

endmodule

/* rtl/core/ttge_ctrl.sv */
// ----------------------------------------------------------------------------
// ttge_ctrl
// Sequencer: clearing pass after reset, byte dispatch, tab and scroll loops,
// and the result strobe.
// ----------------------------------------------------------------------------
module ttge_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ttge_pkg::status_type status,
   output ttge_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_TAB,
      ST_SCROLL,
      ST_PUT,
      ST_READ,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;
   logic      put_after_ff, put_after_in;

   // next state and command
   always_comb begin
      state_in     = state_ff;
      strobe_in    = 1'b0;
      put_after_in = put_after_ff;
      cmd          = ttge_pkg::CMD_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd = ttge_pkg::CMD_CLEAR_STEP;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd      = ttge_pkg::CMD_LATCH;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_read) begin
               state_in = ST_READ;
            end else if (status.phase != ttge_pkg::PHASE_NORMAL) begin
               cmd      = ttge_pkg::CMD_ESCAPE;
               state_in = ST_RESP;
            end else begin
               state_in = ST_RESP;
               unique case (status.bcls)
                  ttge_pkg::BCLS_ESC: cmd = ttge_pkg::CMD_ESCAPE;
                  ttge_pkg::BCLS_LF: begin
                     cmd          = ttge_pkg::CMD_NEWLINE;
                     put_after_in = 1'b0;
                     if (status.line_last) begin
                        state_in = ST_SCROLL;
                     end
                  end
                  ttge_pkg::BCLS_CR: cmd = ttge_pkg::CMD_RETURN;
                  ttge_pkg::BCLS_ERASE: begin
                     if (!status.col_zero) begin
                        cmd = ttge_pkg::CMD_ERASE;
                     end
                  end
                  ttge_pkg::BCLS_TAB: begin
                     cmd      = ttge_pkg::CMD_TAB_START;
                     state_in = ST_TAB;
                  end
                  ttge_pkg::BCLS_PRINT: begin
                     // deferred wrap first, then the write
                     if (status.col_pending) begin
                        cmd          = ttge_pkg::CMD_NEWLINE;
                        put_after_in = 1'b1;
                        state_in     = status.line_last ? ST_SCROLL : ST_PUT;
                     end else begin
                        cmd = ttge_pkg::CMD_PUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_TAB: begin
            if (status.tab_done) begin
               state_in = ST_RESP;
            end else begin
               cmd = ttge_pkg::CMD_TAB_STEP;
            end
         end
         ST_SCROLL: begin
            cmd = ttge_pkg::CMD_SCROLL_STEP;
            if (status.scroll_last) begin
               state_in = put_after_ff ? ST_PUT : ST_RESP;
            end
         end
         ST_PUT: begin
            cmd      = ttge_pkg::CMD_PUT;
            state_in = ST_RESP;
         end
         ST_READ: state_in = ST_RESP;
         ST_RESP: begin
            cmd       = ttge_pkg::CMD_RESPOND;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         strobe_ff    <= 1'b0;
         put_after_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         strobe_ff    <= strobe_in;
         put_after_ff <= put_after_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

/* rtl/core/text_terminal_grid_engine_unit.sv */
// Sequence: a read is latched, dispatched, read from the registered grid and answered.
//   A byte adds a put on a deferred wrap, cursor steps on a tab, a row blank on a scroll.
// Throughput: a new word is taken in the cycle rsp_strobe is high (busy drops then).
// Reset: synchronous; afterwards the grid is blanked with busy high.
//   Results cannot be stalled: rsp_strobe lasts one cycle.
// ----------------------------------------------------------------------------
// text_terminal_grid_engine_unit
// Character grid terminal with cursor, deferred wrap, scrolling and CSI skip.
// ----------------------------------------------------------------------------
`include "text_terminal_grid_engine_unit_assert.svh"

module text_terminal_grid_engine_unit #(
   parameter int unsigned COLUMNS = ttge_pkg::DEF_COLUMNS,
   parameter int unsigned ROWS    = ttge_pkg::DEF_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_type,
   input  logic [7:0] req_data_byte,
   input  logic [4:0] req_read_row,
   input  logic [6:0] req_read_col,
   output logic       rsp_strobe,
   output logic [6:0] rsp_cell_char,
   output logic [6:0] rsp_cursor_col,
   output logic [4:0] rsp_cursor_row,
   output logic [1:0] rsp_escape_phase
);

   ttge_pkg::cmd_type    cmd;
   ttge_pkg::status_type status;

   // sequencer
   ttge_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // grid and cursor datapath
   ttge_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_data_byte    (req_data_byte),
      .req_read_row     (req_read_row),
      .req_read_col     (req_read_col),
      .status           (status),
      .rsp_cell_char    (rsp_cell_char),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_escape_phase (rsp_escape_phase)
   );

   // checks
   `TTGE_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy, "result word while busy")
   `TTGE_ASSERT_NEXT(a_no_early_word, start && !busy, !rsp_strobe, "result right after accept")
   `TTGE_ASSERT_NOW(a_row_range, rsp_strobe, 32'(rsp_cursor_row) < ROWS, "cursor row out of range")
   `TTGE_ASSERT_NOW(a_no_read_in_seq, cmd == ttge_pkg::CMD_SCROLL_STEP, !status.is_read, "scroll on a read")

endmodule
